[hdl/dirichlet_sde_particle_step_defines.svh]
// ----------------------------------------------------------------------------
// Dirichlet SDE particle step: assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef DIRICHLET_SDE_PARTICLE_STEP_DEFINES_SVH
`define DIRICHLET_SDE_PARTICLE_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define DSDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define DSDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DSDE_ASSERT(label, prop, msg)
`define DSDE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hdl/dsde_pkg.sv]
// ----------------------------------------------------------------------------
// Dirichlet SDE particle step package
// Payload types, register codes, and fixed-point helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dsde_pkg;

  localparam int NumRegs     = 7;
  localparam int RegW        = 31;
  localparam int SqrtStages  = 17;
  localparam int LaneStages  = 27;
  localparam int PipeStages  = LaneStages + 2;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    RegTimeStep     = 3'd0,
    RegTargetFirst  = 3'd1,
    RegTargetSecond = 3'd2,
    RegRateFirst    = 3'd3,
    RegRateSecond   = 3'd4,
    RegSpreadFirst  = 3'd5,
    RegSpreadSecond = 3'd6
  } reg_idx_e;

  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    31'd53687091, 31'd671088640, 31'd429496730, 31'd107374182,
    31'd1610612736, 31'd13421773, 31'd322122547
  };

  typedef logic signed [39:0] wide_t;
  typedef logic [71:0]        prod_t;

  typedef struct packed {
    logic signed [31:0] scalar_first;
    logic signed [31:0] scalar_second;
    logic signed [31:0] noise_first;
    logic signed [31:0] noise_second;
    logic               last_particle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_first;
    logic signed [31:0] new_second;
    logic               saturated;
    logic               last_out;
  } out_t;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] w;
    wide_t              drift;
  } side_t;

  typedef struct packed {
    logic [37:0] rem;
    logic [33:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } lane_out_t;

  function automatic logic [39:0] mag40(wide_t a);
    return a[39] ? 40'(-a) : 40'(a);
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic prod_t umul(logic [39:0] a, logic [31:0] b);
    return {32'b0, a} * {40'b0, b};
  endfunction

  // Scale a magnitude product down by 2^sh, rounding ties away from zero.
  function automatic wide_t round_prod(prod_t p, logic neg, int sh);
    prod_t t;
    t = (p + (72'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(t[39:0]) : $signed(t[39:0]);
  endfunction

  // One digit of the restoring square root.
  function automatic sq_t sqrt_step(sq_t a, logic [1:0] pair);
    sq_t         r;
    logic [37:0] trial;
    r.rem  = {a.rem[35:0], pair};
    r.root = {a.root[32:0], 1'b0};
    trial  = {3'b0, r.root, 1'b1};
    if (r.rem >= trial) begin
      r.rem     = r.rem - trial;
      r.root[0] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/dsde_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined square root
// Truncated root of a Q.30 value, two root bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dsde_sqrt
  import dsde_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic [SqrtStages-1:0] en_i,
  input  wire logic [37:0]           rad_i,
  input  wire side_t                 side_i,
  output logic [33:0]                root_o,
  output side_t                      side_o
);

  sq_t         st_q   [SqrtStages];
  logic [37:0] rad_q  [SqrtStages];
  side_t       side_q [SqrtStages];

  for (genvar t = 0; t < SqrtStages; t++) begin : g_stage
    localparam int I0 = 33 - 2 * t;
    localparam int I1 = 32 - 2 * t;
    sq_t         cur;
    sq_t         mid;
    sq_t         nxt;
    logic [37:0] cur_rad;
    side_t       cur_side;
    logic [67:0] xw;

    // Stage inputs come from the lane or from the previous stage.
    if (t == 0) begin : g_first
      assign cur      = '0;
      assign cur_rad  = rad_i;
      assign cur_side = side_i;
    end else begin : g_next
      assign cur      = st_q[t-1];
      assign cur_rad  = rad_q[t-1];
      assign cur_side = side_q[t-1];
    end

    // Two dependent digits, radicand scaled by 2^30.
    assign xw  = {cur_rad, 30'b0};
    assign mid = sqrt_step(cur, xw[2*I0+1 -: 2]);
    assign nxt = sqrt_step(mid, xw[2*I1+1 -: 2]);

    always_ff @(posedge clk_i) begin
      if (en_i[t]) begin
        st_q[t]   <= nxt;
        rad_q[t]  <= cur_rad;
        side_q[t] <= cur_side;
      end
    end
  end

  assign root_o = st_q[SqrtStages-1].root;
  assign side_o = side_q[SqrtStages-1];

endmodule

`default_nettype wire

[hdl/dsde_lane.sv]
// ----------------------------------------------------------------------------
// Per-scalar update lane
// Drift, variance, square root and noise term for one scalar, then saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dsde_lane
  import dsde_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic [LaneStages-1:0] en_i,
  input  wire logic signed [31:0]    y_i,
  input  wire logic signed [31:0]    w_i,
  input  wire wide_t                 yn_i,
  input  wire logic [RegW-1:0]       s_i,
  input  wire logic [RegW-1:0]       b_i,
  input  wire logic [RegW-1:0]       k_i,
  input  wire logic [RegW-1:0]       dt_i,
  output lane_out_t                  res_o
);

  logic signed [32:0] oms;
  logic signed [31:0] y_q [7];
  logic signed [31:0] w_q [7];
  prod_t p1p_q, p2p_q, q1p_q, q2p_q, d1p_q, q3p_q, d2p_q, ap_q;
  logic  p1n_q, p2n_q, q1n_q, q2n_q, d1n_q, q3n_q, d2n_q, apn_q;
  wide_t p1_q, p2_q, v1_q, diff_q, v2_q, d1_q, vr_q, drift_q, dif_q;
  logic [37:0] rad_q;
  logic [33:0] amp;
  side_t       sq_side;
  logic signed [31:0] y25_q, y26_q;
  wide_t       dr25_q, dr26_q;
  logic signed [40:0] sum;
  lane_out_t   res_q;

  // The complement 1 - S; S beyond one makes it negative.
  assign oms = 33'sd1073741824 - $signed({2'b00, s_i});

  // First products: yn*S, y*(1-S), yn*k.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1p_q  <= umul(mag40(yn_i), {1'b0, s_i});
      p1n_q  <= yn_i[39];
      p2p_q  <= umul({8'b0, mag32(y_i)}, 32'(oms[32] ? -oms : oms));
      p2n_q  <= y_i[31] ^ oms[32];
      q1p_q  <= umul(mag40(yn_i), {1'b0, k_i});
      q1n_q  <= yn_i[39];
      y_q[0] <= y_i;
      w_q[0] <= w_i;
    end
  end

  // Round the first products.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p1_q   <= round_prod(p1p_q, p1n_q, 30);
      p2_q   <= round_prod(p2p_q, p2n_q, 30);
      v1_q   <= round_prod(q1p_q, q1n_q, 30);
      y_q[1] <= y_q[0];
      w_q[1] <= w_q[0];
    end
  end

  // Drift difference; variance times y.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      diff_q <= p1_q - p2_q;
      q2p_q  <= umul(mag40(v1_q), mag32(y_q[1]));
      q2n_q  <= v1_q[39] ^ y_q[1][31];
      y_q[2] <= y_q[1];
      w_q[2] <= w_q[1];
    end
  end

  // Difference times b; round the variance product.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      d1p_q  <= umul(mag40(diff_q), {1'b0, b_i});
      d1n_q  <= diff_q[39];
      v2_q   <= round_prod(q2p_q, q2n_q, 30);
      y_q[3] <= y_q[2];
      w_q[3] <= w_q[2];
    end
  end

  // Halve with b; variance times dt.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      d1_q   <= round_prod(d1p_q, d1n_q, 31);
      q3p_q  <= umul(mag40(v2_q), {1'b0, dt_i});
      q3n_q  <= v2_q[39];
      y_q[4] <= y_q[3];
      w_q[4] <= w_q[3];
    end
  end

  // Drift times dt; round the final variance.
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      d2p_q  <= umul(mag40(d1_q), {1'b0, dt_i});
      d2n_q  <= d1_q[39];
      vr_q   <= round_prod(q3p_q, q3n_q, 30);
      y_q[5] <= y_q[4];
      w_q[5] <= w_q[4];
    end
  end

  // Final drift; a variance that is not positive gives a zero root.
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      drift_q <= round_prod(d2p_q, d2n_q, 30);
      rad_q   <= (vr_q > 0) ? vr_q[37:0] : '0;
      y_q[6]  <= y_q[5];
      w_q[6]  <= w_q[5];
    end
  end

  dsde_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i[SqrtStages+6:7]),
    .rad_i  (rad_q),
    .side_i ('{y: y_q[6], w: w_q[6], drift: drift_q}),
    .root_o (amp),
    .side_o (sq_side)
  );

  // Diffusion amplitude times noise.
  always_ff @(posedge clk_i) begin
    if (en_i[SqrtStages+7]) begin
      ap_q   <= umul({6'b0, amp}, mag32(sq_side.w));
      apn_q  <= sq_side.w[31];
      y25_q  <= sq_side.y;
      dr25_q <= sq_side.drift;
    end
  end

  // Round the diffusion term from Q.58 back to Q.30.
  always_ff @(posedge clk_i) begin
    if (en_i[SqrtStages+8]) begin
      dif_q  <= round_prod(ap_q, apn_q, 28);
      y26_q  <= y25_q;
      dr26_q <= dr25_q;
    end
  end

  // Sum and saturate to the signed word.
  assign sum = 41'(y26_q) + 41'(dr26_q) + 41'(dif_q);

  always_ff @(posedge clk_i) begin
    if (en_i[SqrtStages+9]) begin
      if (sum > 41'sd2147483647) begin
        res_q <= '{val: 32'sh7fffffff, clip: 1'b1};
      end else if (sum < -41'sd2147483648) begin
        res_q <= '{val: 32'sh80000000, clip: 1'b1};
      end else begin
        res_q <= '{val: sum[31:0], clip: 1'b0};
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hdl/dirichlet_sde_particle_step.sv]
// ----------------------------------------------------------------------------
// Dirichlet SDE particle step
// One Euler-Maruyama step for a particle with two mixing scalars.
// ----------------------------------------------------------------------------
// Usage:
// A particle beat enters on in_valid_i while in_stall_o is low and carries
// both scalars, both noise samples and the last-particle marker. Each beat
// yields exactly one result beat on out_valid_o, taken when out_stall_i is
// low, with the advanced scalars, a saturation flag and the marker copy.
// Throughput is one particle per cycle while out_stall_i is low, set by
// the 29-stage pipeline: two input stages, 27 lane stages holding the
// multiply and round steps and a 17-stage square root at two root bits per
// stage. When the receiver stalls, the result holds and earlier stages keep
// moving into empty slots; in_stall_o rises only once every stage is full.
// Reset empties the pipeline and loads the default coefficients. The
// configuration port is a write enable, a 3-bit register index and 31-bit
// data; it takes effect on the next edge. The user must write it only
// while idle; the block itself does not enforce this.
// Index seven is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dirichlet_sde_particle_step_defines.svh"

module dirichlet_sde_particle_step
  import dsde_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [RegW-1:0]  cfg_data_i
);

  logic [RegW-1:0]       cfg_q [NumRegs];
  logic [PipeStages-1:0] vld_q;
  logic [PipeStages-1:0] last_q;
  logic [PipeStages-1:0] en;
  in_t                   in_q;
  wide_t                 yn_q;
  logic signed [31:0]    y0_q, y1_q, w0_q, w1_q;
  lane_out_t             res0, res1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) cfg_q[r] <= RegReset[r];
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegTimeStep:     cfg_q[RegTimeStep]     <= cfg_data_i;
        RegTargetFirst:  cfg_q[RegTargetFirst]  <= cfg_data_i;
        RegTargetSecond: cfg_q[RegTargetSecond] <= cfg_data_i;
        RegRateFirst:    cfg_q[RegRateFirst]    <= cfg_data_i;
        RegRateSecond:   cfg_q[RegRateSecond]   <= cfg_data_i;
        RegSpreadFirst:  cfg_q[RegSpreadFirst]  <= cfg_data_i;
        RegSpreadSecond: cfg_q[RegSpreadSecond] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[PipeStages-1] = ~vld_q[PipeStages-1] | ~out_stall_i;
    for (int k = PipeStages - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign in_stall_o = ~en[0];

  // Valid bits and the last-particle marker travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < PipeStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) last_q[0] <= in_data_i.last_particle;
    for (int k = 1; k < PipeStages; k++) begin
      if (en[k]) last_q[k] <= last_q[k-1];
    end
  end

  // Input register, then the remainder yn = 1 - y0 - y1.
  always_ff @(posedge clk_i) begin
    if (en[0]) in_q <= in_data_i;
    if (en[1]) begin
      yn_q <= 40'sd1073741824 - 40'(in_q.scalar_first) - 40'(in_q.scalar_second);
      y0_q <= in_q.scalar_first;
      y1_q <= in_q.scalar_second;
      w0_q <= in_q.noise_first;
      w1_q <= in_q.noise_second;
    end
  end

  dsde_lane u_lane_first (
    .clk_i (clk_i),
    .en_i  (en[PipeStages-1:2]),
    .y_i   (y0_q),
    .w_i   (w0_q),
    .yn_i  (yn_q),
    .s_i   (cfg_q[RegTargetFirst]),
    .b_i   (cfg_q[RegRateFirst]),
    .k_i   (cfg_q[RegSpreadFirst]),
    .dt_i  (cfg_q[RegTimeStep]),
    .res_o (res0)
  );

  dsde_lane u_lane_second (
    .clk_i (clk_i),
    .en_i  (en[PipeStages-1:2]),
    .y_i   (y1_q),
    .w_i   (w1_q),
    .yn_i  (yn_q),
    .s_i   (cfg_q[RegTargetSecond]),
    .b_i   (cfg_q[RegRateSecond]),
    .k_i   (cfg_q[RegSpreadSecond]),
    .dt_i  (cfg_q[RegTimeStep]),
    .res_o (res1)
  );

  // Result beat.
  assign out_valid_o = vld_q[PipeStages-1];
  assign out_data_o  = '{new_first:  res0.val,
                         new_second: res1.val,
                         saturated:  res0.clip | res1.clip,
                         last_out:   last_q[PipeStages-1]};

  // The input stalls only when every stage holds an item.
  `DSDE_ASSERT_ALWAYS(a_stall_full, in_stall_o |-> (&vld_q), "input stalled with a free stage")
  // An accepted beat always lands in the first stage.
  `DSDE_ASSERT(a_accept_lands, (in_valid_i && !in_stall_o) |=> vld_q[0], "accepted beat lost")
  // A taken result with nothing behind it leaves the output empty.
  `DSDE_ASSERT(a_drain, (out_valid_o && !out_stall_i && !vld_q[PipeStages-2]) |=> !out_valid_o,
               "result repeated")

endmodule

`default_nettype wire
